[src/cubic_bezier_y_from_x_defines.svh]
// ----------------------------------------------------------------------------
// cubic_bezier_y_from_x_defines
// assertion macros for the bezier solver
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_Y_FROM_X_DEFINES_SVH
`define CUBIC_BEZIER_Y_FROM_X_DEFINES_SVH

// implication checked on every clock edge, reset masks it
`define CBZ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBZ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/cbz_pkg.sv]
// ----------------------------------------------------------------------------
// cbz_pkg
// types, constants and helpers shared by the bezier solver
// ----------------------------------------------------------------------------
`default_nettype none
package cbz_pkg;
  localparam int unsigned TBits  = 24;
  localparam int unsigned WBits  = 30;
  localparam int unsigned NCells = 4;
  localparam int unsigned NRegs  = 8;
  localparam int unsigned IdxW   = 3;

  typedef struct packed {
    logic signed [31:0] query_x;
    logic [30:0]        tolerance;
    logic [4:0]         max_steps;
  } req_t;

  typedef struct packed {
    logic signed [31:0] y_value;
    logic               found;
  } rsp_t;

  // one cell's view of the running sums
  typedef struct packed {
    logic signed [63:0] sx;
    logic signed [63:0] sy;
  } acc_t;

  // t with WBits fraction bits
  function automatic logic [WBits:0] to_tw(input logic [TBits:0] t);
    logic [63:0] w;
    begin
      if (TBits >= WBits) w = 64'(t) >> (TBits - WBits);
      else w = 64'(t) << (WBits - TBits);
      if (w > (64'd1 << WBits)) w = 64'd1 << WBits;
      to_tw = w[WBits:0];
    end
  endfunction

  // round a Q(WBits) sum half up
  function automatic logic signed [31:0] scale_down(input logic signed [63:0] v);
    logic signed [63:0] r;
    begin
      r = (v + (64'sd1 <<< (WBits - 1))) >>> WBits;
      scale_down = r[31:0];
    end
  endfunction
endpackage
`default_nettype wire

[src/cbz_cell.sv]
// ----------------------------------------------------------------------------
// cbz_cell
// one term of the bernstein sum: adds Pi*bi to the sums from its neighbor
// ----------------------------------------------------------------------------
`default_nettype none
module cbz_cell import cbz_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [31:0] px_i,
  input  wire logic signed [31:0] py_i,
  input  wire logic [WBits:0]     b_i,
  input  wire acc_t               acc_i,
  output acc_t                    acc_o
);
  logic signed [63:0] mx, my;
  assign mx = 64'(px_i) * $signed({33'd0, b_i});
  assign my = 64'(py_i) * $signed({33'd0, b_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_o.sx <= acc_i.sx + mx;
      acc_o.sy <= acc_i.sy + my;
    end
  end
endmodule
`default_nettype wire

[src/cbz_basis.sv]
// ----------------------------------------------------------------------------
// cbz_basis
// bernstein weights of t, computed in registered stages
// ----------------------------------------------------------------------------
`default_nettype none
module cbz_basis import cbz_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic [TBits:0] t_i,
  output logic [WBits:0]      b0_o,
  output logic [WBits:0]      b1_o,
  output logic [WBits:0]      b2_o,
  output logic [WBits:0]      b3_o
);
  logic [WBits:0] tw_q, aw_q, aa_q, tt_q;
  logic [63:0] p_aa, p_tt;

  assign p_aa = 64'(aw_q) * 64'(aw_q);
  assign p_tt = 64'(tw_q) * 64'(tw_q);

  always_ff @(posedge clk_i) begin
    tw_q <= to_tw(t_i);
    aw_q <= (WBits+1)'(64'd1 << WBits) - to_tw(t_i);
    aa_q <= p_aa[WBits +: WBits+1];
    tt_q <= p_tt[WBits +: WBits+1];
    b0_o <= (WBits+1)'((64'(aa_q) * 64'(aw_q)) >> WBits);
    b1_o <= (WBits+1)'((64'd3 * 64'(tw_q) * 64'(aa_q)) >> WBits);
    b2_o <= (WBits+1)'((64'd3 * 64'(tt_q) * 64'(aw_q)) >> WBits);
    b3_o <= (WBits+1)'((64'(tt_q) * 64'(tw_q)) >> WBits);
  end
endmodule
`default_nettype wire

[src/cubic_bezier_y_from_x.sv]
// ----------------------------------------------------------------------------
// cubic_bezier_y_from_x
// y of a cubic bezier curve at a query x by bisection on t
// ----------------------------------------------------------------------------
// usage
//   request channel: req_valid_i / req_stall_o / req_i (query_x, tolerance,
//   max_steps). response channel: rsp_valid_o / rsp_stall_i / rsp_o.
//   control points are written through cfg_we_i / cfg_idx_i / cfg_data_i
//   while the block is idle; the user must keep to this, the block itself
//   does not enforce it. one request at a time. each bisection step runs the
//   basis stages, then the chain of bernstein cells, then the compare.
//   the step time is set by the basis pipeline and cell chain in series.
//   the search runs up to max_steps steps, and a match ends it early. a
//   request with a degenerate span (pts_q[6] <= pts_q[0]) or zero steps
//   answers without a search. a new request is taken only once the previous
//   search is done and the state machine is back in idle.
//   the response is held in an output register until taken; a new request
//   is accepted while it waits, and a finished search waits while that
//   register still holds a stalled response. reset returns the points to
//   their defaults and drops any request in flight.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cubic_bezier_y_from_x_defines.svh"
module cubic_bezier_y_from_x import cbz_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_valid_i,
  output logic                 req_stall_o,
  input  wire req_t            req_i,
  output logic                 rsp_valid_o,
  input  wire logic            rsp_stall_i,
  output rsp_t                 rsp_o,
  input  wire logic            cfg_we_i,
  input  wire logic [IdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]     cfg_data_i
);
  typedef enum logic [1:0] {IDLE, EVAL, DONE} state_e;

  logic signed [31:0] pts_q [NRegs];
  state_e             state_q;
  logic [3:0]         cyc_q;
  logic [4:0]         left_q;
  logic [TBits:0]     t_q, lo_q, hi_q;
  req_t               job_q;
  logic signed [31:0] yres_q;
  logic               fnd_q;
  rsp_t               out_q;
  logic               ovalid_q;
  logic               load_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_q[0] <= '0; pts_q[1] <= '0; pts_q[2] <= '0; pts_q[3] <= '0;
      pts_q[4] <= 32'sd65536; pts_q[5] <= 32'sd65536;
      pts_q[6] <= 32'sd65536; pts_q[7] <= 32'sd65536;
    end else if (cfg_we_i) begin
      pts_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // basis weights
  logic [WBits:0] b [NCells];
  cbz_basis u_basis (.clk_i, .t_i(t_q), .b0_o(b[0]), .b1_o(b[1]), .b2_o(b[2]),
                     .b3_o(b[3]));

  // chain of cells: each cell k is enabled by its own value of the step counter cyc_q, in order of k
  acc_t acc [NCells+1];
  assign acc[0] = '0;
  for (genvar k = 0; k < NCells; k++) begin : g_cell
    cbz_cell u_cell (
      .clk_i, .en_i(cyc_q == 4'(3 + k)),
      .px_i(pts_q[2*k]), .py_i(pts_q[2*k+1]), .b_i(b[k]),
      .acc_i(acc[k]), .acc_o(acc[k+1]));
  end

  logic signed [31:0] rx, ry;
  logic signed [32:0] diff, adiff;
  logic [TBits:0]     nlo, nhi;
  assign rx    = scale_down(acc[NCells].sx);
  assign ry    = scale_down(acc[NCells].sy);
  assign diff  = 33'(job_q.query_x) - 33'(rx);
  assign adiff = diff[32] ? -diff : diff;
  assign nlo   = (rx < job_q.query_x) ? t_q : lo_q;
  assign nhi   = (rx < job_q.query_x) ? hi_q : t_q;

  // finished result moves to the output register once it is free
  assign load_out    = (state_q == DONE) && (!ovalid_q || !rsp_stall_i);
  assign req_stall_o = (state_q != IDLE);
  assign rsp_valid_o = ovalid_q;
  assign rsp_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= IDLE;
      cyc_q    <= '0;
      left_q   <= '0;
      t_q      <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      job_q    <= '0;
      yres_q   <= '0;
      fnd_q    <= 1'b0;
      out_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      unique case (state_q)
        IDLE: begin
          if (req_valid_i) begin
            job_q  <= req_i;
            left_q <= req_i.max_steps;
            lo_q   <= '0;
            hi_q   <= (TBits+1)'(1) << TBits;
            t_q    <= (TBits+1)'(1) << (TBits - 1);
            cyc_q  <= '0;
            yres_q <= '0;
            fnd_q  <= 1'b0;
            if (req_i.max_steps == 5'd0 || pts_q[6] <= pts_q[0]) state_q <= DONE;
            else state_q <= EVAL;
          end
        end
        EVAL: begin
          if (cyc_q == 4'(3 + NCells)) begin
            cyc_q <= '0;
            if (adiff <= 33'(job_q.tolerance)) begin
              yres_q  <= ry;
              fnd_q   <= 1'b1;
              state_q <= DONE;
            end else begin
              lo_q   <= nlo;
              hi_q   <= nhi;
              t_q    <= nlo + ((nhi - nlo) >> 1);
              left_q <= left_q - 5'd1;
              if (left_q == 5'd1) state_q <= DONE;
            end
          end else begin
            cyc_q <= cyc_q + 4'd1;
          end
        end
        DONE: begin
          if (load_out) state_q <= IDLE;
        end
        default: state_q <= IDLE;
      endcase

      // output register
      if (load_out) begin
        out_q    <= '{y_value: yres_q, found: fnd_q};
        ovalid_q <= 1'b1;
      end else if (!rsp_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  `CBZ_ASSERT_IMP(a_found_y_zero, clk_i, rst_ni, rsp_valid_o && !rsp_o.found, rsp_o.y_value == 32'sd0, "not-found response carries nonzero y")
  `CBZ_ASSERT_IMP(a_interval, clk_i, rst_ni, state_q == EVAL, lo_q <= t_q && t_q <= hi_q, "t left bisection interval")
  `CBZ_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_o && rsp_stall_i, rsp_valid_o && $stable(rsp_o), "stalled response changed")
endmodule
`default_nettype wire
